// ----- rtl/core/grdr_pkg.sv -----
package grdr_pkg;

  localparam int FRAME_DEPTH = 32;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
  localparam int EMIT_MAX    = (FRAME_DEPTH < 32) ? FRAME_DEPTH : 32;
  localparam int LEN_W       = 6;
  localparam int IDX_W       = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  FN_ANY         = 8'h00;
  localparam logic [7:0]  ACK_REJECT     = 8'hEE;
  localparam logic [7:0]  ACK_OK         = 8'h02;
  localparam logic [7:0]  ACK_COND       = 8'hE2;
  localparam logic [7:0]  RST_DEV_ADDR   = 8'd1;
  localparam logic [15:0] RST_TIMEOUT_MS = 16'd200;
  localparam logic [7:0]  RST_GAP_MS     = 8'd5;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_DEVICE_ADDRESS = 2'd0,
    CFG_RESPONSE_TIMEOUT = 2'd1,
    CFG_FRAME_GAP = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_COND    = 3'd1,
    ST_REJECT  = 3'd2,
    ST_FRAME   = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_LOAD,
    B_DRAIN
  } back_state_t;

  typedef struct packed {
    logic             timeout;
    logic [LEN_W-1:0] len;
    status_t          status;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

endpackage

// ----- rtl/core/grdr_queue.sv -----
module grdr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  grdr_pkg::job_t push_job,
  input  logic          pop,
  output grdr_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);
  import grdr_pkg::*;

  job_t               entries [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full     = (count == Q_CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job popped from empty queue");

endmodule

// ----- rtl/core/grdr_front.sv -----
module grdr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  logic [1:0]     opcode,
  input  logic [7:0]     rx_byte,
  input  logic [7:0]     expected_function,
  input  logic           data_frame,
  input  logic [5:0]     min_length,
  input  logic [7:0]     device_address,
  input  logic [15:0]    response_timeout_ms,
  input  logic [7:0]     gap_limit,
  input  logic           q_full,
  input  logic           q_empty,
  input  logic           back_busy,
  output logic           push,
  output grdr_pkg::job_t push_job,
  output grdr_pkg::wr_t  wr
);
  import grdr_pkg::*;

  logic             waiting, waiting_next;
  logic             matched, matched_next;
  logic [CNT_W-1:0] count, count_next;
  logic [15:0]      elapsed, elapsed_next;
  logic [7:0]       idle, idle_next;
  logic [7:0]       want_fn;
  logic             want_data;
  logic [5:0]       want_min;
  logic [7:0]       b0, b0_next;
  logic [7:0]       b1, b1_next;
  logic [7:0]       b2, b2_next;
  logic             accept;
  logic             finish;
  logic [LEN_W-1:0] len;

  function automatic status_t judge(input logic [LEN_W-1:0] l, input logic [7:0] c1,
                                    input logic [7:0] c2, input logic data_rules,
                                    input logic [7:0] fn, input logic [5:0] min_l);
    logic long_enough;
    long_enough = (l >= LEN_W'(4));
    if (long_enough && c1 == FN_ANY && c2 == ACK_REJECT) begin
      return ST_REJECT;
    end
    if (data_rules) begin
      if (l < min_l || c1 != fn) begin
        return ST_FRAME;
      end
      return ST_OK;
    end
    if (long_enough && c2 == ACK_OK) begin
      return ST_OK;
    end
    if (long_enough && c2 == ACK_COND) begin
      return ST_COND;
    end
    return ST_FRAME;
  endfunction

  // bytes wait while the buffer is still being read out; every item waits while the job queue is full
  assign item_stall = q_full || (opcode == OP_BYTE && (!q_empty || back_busy));
  assign accept     = item_valid && !item_stall;

  always_comb begin
    waiting_next = waiting;
    matched_next = matched;
    count_next   = count;
    elapsed_next = elapsed;
    idle_next    = idle;
    b0_next      = b0;
    b1_next      = b1;
    b2_next      = b2;
    finish       = 1'b0;
    wr.en        = 1'b0;
    wr.addr      = count[ADDR_W-1:0];
    wr.data      = rx_byte;
    case (opcode)
      OP_START: begin
        waiting_next = 1'b1;
        matched_next = 1'b0;
        count_next   = '0;
        elapsed_next = '0;
        idle_next    = '0;
      end
      OP_BYTE: begin
        if (waiting) begin
          if (count < CNT_W'(FRAME_DEPTH)) begin
            wr.en      = accept;
            count_next = count + 1'b1;
            if (count == CNT_W'(0)) b0_next = rx_byte;
            if (count == CNT_W'(1)) b1_next = rx_byte;
            if (count == CNT_W'(2)) b2_next = rx_byte;
          end
          idle_next = '0;
          if (!matched && count_next >= CNT_W'(2) && b0_next == device_address &&
              (b1_next == want_fn || b1_next == FN_ANY)) begin
            matched_next = 1'b1;
          end
          finish = (count_next >= CNT_W'(FRAME_DEPTH));
        end
      end
      OP_TICK: begin
        if (waiting) begin
          if (elapsed != 16'hFFFF) elapsed_next = elapsed + 1'b1;
          if (matched && idle != 8'hFF) idle_next = idle + 1'b1;
          finish = (elapsed_next >= response_timeout_ms) ||
                   (matched && idle_next >= gap_limit);
        end
      end
      default: begin
      end
    endcase
    if (finish) begin
      waiting_next = 1'b0;
    end
    len = (count_next > CNT_W'(EMIT_MAX)) ? LEN_W'(EMIT_MAX) : LEN_W'(count_next);
    push_job.timeout = !matched_next;
    push_job.len     = len;
    push_job.status  = judge(len, b1_next, b2_next, want_data, want_fn, want_min);
    push             = accept && finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting   <= 1'b0;
      matched   <= 1'b0;
      count     <= '0;
      elapsed   <= '0;
      idle      <= '0;
      want_fn   <= '0;
      want_data <= 1'b0;
      want_min  <= '0;
    end else if (accept) begin
      waiting <= waiting_next;
      matched <= matched_next;
      count   <= count_next;
      elapsed <= elapsed_next;
      idle    <= idle_next;
      if (opcode == OP_START) begin
        want_fn   <= expected_function;
        want_data <= data_frame;
        want_min  <= min_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b0 <= b0_next;
      b1 <= b1_next;
      b2 <= b2_next;
    end
  end

endmodule

// ----- rtl/core/grdr_back.sv -----
module grdr_back (
  input  logic                  clk,
  input  logic                  rst,
  input  grdr_pkg::wr_t         wr,
  input  logic                  q_empty,
  input  grdr_pkg::job_t        head_job,
  output logic                  pop,
  output logic                  busy,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [7:0]            res_data,
  output logic [4:0]            res_index,
  output logic [5:0]            res_len,
  output grdr_pkg::status_t     res_status,
  output logic                  res_last
);
  import grdr_pkg::*;

  back_state_t       state, state_next;
  logic [7:0]        mem [FRAME_DEPTH];
  logic [7:0]        rd_q;
  logic [ADDR_W-1:0] k;
  logic [LEN_W-1:0]  job_len;
  status_t           job_status;
  logic              res_take;

  assign busy     = (state != B_IDLE);
  assign res_take = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q <= mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = head_job.timeout ? B_DRAIN : B_READ;
        end
      end
      B_READ: state_next = B_LOAD;
      B_LOAD: state_next = B_DRAIN;
      B_DRAIN: begin
        if (res_take) begin
          state_next = res_last ? B_IDLE : B_READ;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((pop && head_job.timeout) || state == B_LOAD) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_len    <= head_job.len;
      job_status <= head_job.status;
      k          <= '0;
      if (head_job.timeout) begin
        res_data   <= '0;
        res_index  <= '0;
        res_len    <= '0;
        res_status <= ST_TIMEOUT;
        res_last   <= 1'b1;
      end
    end
    if (state == B_LOAD) begin
      res_data   <= rd_q;
      res_index  <= IDX_W'(k);
      res_len    <= job_len;
      res_status <= job_status;
      res_last   <= (LEN_W'(k) + LEN_W'(1) == job_len);
    end
    if (state == B_DRAIN && res_take && !res_last) begin
      k <= k + 1'b1;
    end
  end

  a_valid_in_drain: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> state == B_DRAIN)
    else $error("result shown outside drain state");
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (res_take && res_last) |=> state == B_IDLE)
    else $error("run did not end after last word");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    state == B_LOAD |=> res_valid)
    else $error("loaded byte not presented");

endmodule

// ----- rtl/core/gap_delimited_response_receiver.sv -----
// channel  | handshake             | word
// item     | item_valid/item_stall | opcode, rx_byte, expected_function, data_frame, min_length
// result   | res_valid/res_stall   | data_byte, byte_index, frame_length, status, last
// config   | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// Front takes one item per cycle unless stalled; a frame end queues a job (queue of 2).
// Back emits each byte word in steps (buffer read, load, present) and holds it
// while the result stalls; a timeout word appears in the cycle after the job is taken.
// Byte items stall while a queued or running frame is read from the buffer.
// Synchronous reset clears control state; the frame buffer is not cleared.
module gap_delimited_response_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] rx_byte,
  input  logic [7:0] expected_function,
  input  logic       data_frame,
  input  logic [5:0] min_length,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] data_byte,
  output logic [4:0] byte_index,
  output logic [5:0] frame_length,
  output logic [2:0] status,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import grdr_pkg::*;

  logic [7:0]  device_address;
  logic [15:0] response_timeout_ms;
  logic [7:0]  gap_limit;
  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        head_job;
  wr_t         wr;
  logic        q_full;
  logic        q_empty;
  logic        back_busy;
  status_t     res_status;

  assign cfg_ready = 1'b1;
  assign status    = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address      <= RST_DEV_ADDR;
      response_timeout_ms <= RST_TIMEOUT_MS;
      gap_limit           <= RST_GAP_MS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS:   device_address      <= cfg_data[7:0];
        CFG_RESPONSE_TIMEOUT: response_timeout_ms <= cfg_data;
        CFG_FRAME_GAP:        gap_limit           <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  grdr_front u_front (
    .clk                (clk),
    .rst                (rst),
    .item_valid         (item_valid),
    .item_stall         (item_stall),
    .opcode             (opcode),
    .rx_byte            (rx_byte),
    .expected_function  (expected_function),
    .data_frame         (data_frame),
    .min_length         (min_length),
    .device_address     (device_address),
    .response_timeout_ms(response_timeout_ms),
    .gap_limit          (gap_limit),
    .q_full             (q_full),
    .q_empty            (q_empty),
    .back_busy          (back_busy),
    .push               (push),
    .push_job           (push_job),
    .wr                 (wr)
  );

  grdr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head_job(head_job),
    .full    (q_full),
    .empty   (q_empty)
  );

  grdr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .q_empty   (q_empty),
    .head_job  (head_job),
    .pop       (pop),
    .busy      (back_busy),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (data_byte),
    .res_index (byte_index),
    .res_len   (frame_length),
    .res_status(res_status),
    .res_last  (last)
  );

endmodule
